@@ rtl/core/vwts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vwts_pkg;

   localparam int COORD_WIDTH     = 24;
   localparam int COORD_FRAC_BITS = 8;
   localparam int COEF_WIDTH      = 16;
   localparam int SIZE_WIDTH      = 16;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + COEF_WIDTH;
   localparam int CLIP_WIDTH = PROD_WIDTH + 2;
   localparam int NUM_WIDTH  = CLIP_WIDTH + 1;
   localparam int DIV_WIDTH  = NUM_WIDTH + SIZE_WIDTH;
   localparam int REM_WIDTH  = DIV_WIDTH + 1;
   localparam int OUT_WIDTH  = 17;
   localparam int QUO_BITS   = OUT_WIDTH;

   localparam logic [OUT_WIDTH-1:0] OUT_MAX  = 17'h0ffff;
   localparam logic [OUT_WIDTH-1:0] OUT_MIN  = 17'h10000;
   localparam logic [OUT_WIDTH-1:0] OUT_CLIP = 17'h1ffff;

   typedef logic signed [CLIP_WIDTH-1:0]   clip_type;
   typedef logic [NUM_WIDTH-1:0]           num_type;
   typedef logic [DIV_WIDTH-1:0]           dividend_type;
   typedef logic [QUO_BITS-1:0]            quo_type;
   typedef logic [3:0][CSR_DATA_WIDTH-1:0] matrix_type;

   typedef struct packed {
      logic clipped;
      logic zero_w;
      logic neg_x;
      logic neg_y;
   } meta_type;

endpackage

`default_nettype wire

@@ rtl/core/vwts_xform.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vwts_xform
   import vwts_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [COORD_WIDTH-1:0] vertex_x,
   input  wire logic signed [COORD_WIDTH-1:0] vertex_y,
   input  wire logic signed [COORD_WIDTH-1:0] vertex_z,
   input  wire logic signed [COORD_WIDTH-1:0] camera_x,
   input  wire logic signed [COORD_WIDTH-1:0] camera_y,
   input  wire logic signed [COORD_WIDTH-1:0] camera_z,
   input  wire matrix_type                    matrix,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output clip_type                           clip_out [4]
);

   logic v0_ff, v1_ff, v2_ff;
   logic en0, en1, en2;

   logic signed [DIFF_WIDTH-1:0] diff_in [3];
   logic signed [DIFF_WIDTH-1:0] diff_ff [3];
   logic signed [PROD_WIDTH-1:0] prod_in [4][4];
   logic signed [PROD_WIDTH-1:0] prod_ff [4][4];
   clip_type                     clip_in [4];
   clip_type                     clip_ff [4];

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign en0      = !v0_ff || en1;
   assign in_ready = en0;

   always_comb begin
      diff_in[0] = DIFF_WIDTH'(vertex_x) - DIFF_WIDTH'(camera_x);
      diff_in[1] = DIFF_WIDTH'(vertex_y) - DIFF_WIDTH'(camera_y);
      diff_in[2] = DIFF_WIDTH'(vertex_z) - DIFF_WIDTH'(camera_z);
   end

   always_comb begin
      logic signed [COEF_WIDTH-1:0] c;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 3; j++) begin
            c = $signed(matrix[i][COEF_WIDTH*j +: COEF_WIDTH]);
            prod_in[i][j] = PROD_WIDTH'(c) * PROD_WIDTH'(diff_ff[j]);
         end
         c = $signed(matrix[i][COEF_WIDTH*3 +: COEF_WIDTH]);
         prod_in[i][3] = PROD_WIDTH'(c) <<< COORD_FRAC_BITS;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         clip_in[i] = CLIP_WIDTH'(prod_ff[i][0]) + CLIP_WIDTH'(prod_ff[i][1])
                    + CLIP_WIDTH'(prod_ff[i][2]) + CLIP_WIDTH'(prod_ff[i][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= in_valid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) diff_ff <= diff_in;
      if (en1) prod_ff <= prod_in;
      if (en2) clip_ff <= clip_in;
   end

   assign out_valid = v2_ff;
   assign clip_out  = clip_ff;

endmodule

`default_nettype wire

@@ rtl/core/vwts_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vwts_prep
   import vwts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire clip_type              clip_in [4],
   input  wire logic [SIZE_WIDTH-1:0] width,
   input  wire logic [SIZE_WIDTH-1:0] height,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output dividend_type               num_x,
   output dividend_type               num_y,
   output num_type                    den,
   output meta_type                   meta
);

   logic va_ff, vb_ff;
   logic ena, enb;

   num_type    nx_in, ny_in, nx_ff, ny_ff;
   clip_type   aw_in, aw_ff;
   meta_type   ma_in, ma_ff, mb_ff;
   dividend_type numx_in, numy_in, numx_ff, numy_ff;
   num_type    den_in, den_ff;

   assign enb      = !vb_ff || out_ready;
   assign ena      = !va_ff || enb;
   assign in_ready = ena;

   always_comb begin
      num_type  tx, ty;
      clip_type az;
      logic     wneg;
      wneg  = clip_in[3][CLIP_WIDTH-1];
      tx    = NUM_WIDTH'(clip_in[3]) - NUM_WIDTH'(clip_in[0]);
      ty    = NUM_WIDTH'(clip_in[3]) - NUM_WIDTH'(clip_in[1]);
      nx_in = tx[NUM_WIDTH-1] ? -tx : tx;
      ny_in = ty[NUM_WIDTH-1] ? -ty : ty;
      aw_in = wneg ? -clip_in[3] : clip_in[3];
      az    = clip_in[2][CLIP_WIDTH-1] ? -clip_in[2] : clip_in[2];
      ma_in.zero_w  = (clip_in[3] == '0);
      ma_in.clipped = (clip_in[3] == '0) || ($unsigned(az) > $unsigned(aw_in));
      ma_in.neg_x   = tx[NUM_WIDTH-1] ^ wneg;
      ma_in.neg_y   = ty[NUM_WIDTH-1] ^ wneg;
   end

   always_comb begin
      numx_in = DIV_WIDTH'(nx_ff) * DIV_WIDTH'(width);
      numy_in = DIV_WIDTH'(ny_ff) * DIV_WIDTH'(height);
      den_in  = {aw_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (ena) va_ff <= in_valid;
         if (enb) vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ena) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         aw_ff <= aw_in;
         ma_ff <= ma_in;
      end
      if (enb) begin
         numx_ff <= numx_in;
         numy_ff <= numy_in;
         den_ff  <= den_in;
         mb_ff   <= ma_ff;
      end
   end

   assign out_valid = vb_ff;
   assign num_x     = numx_ff;
   assign num_y     = numy_ff;
   assign den       = den_ff;
   assign meta      = mb_ff;

endmodule

`default_nettype wire

@@ rtl/core/vwts_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vwts_div
   import vwts_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire dividend_type num_x,
   input  wire dividend_type num_y,
   input  wire num_type      den,
   input  wire meta_type     meta_in,
   output logic              out_valid,
   input  wire logic         out_ready,
   output quo_type           quo_x,
   output quo_type           quo_y,
   output logic              ovf_x,
   output logic              ovf_y,
   output meta_type          meta_out
);

   logic                 v_ff    [QUO_BITS+1];
   logic                 en      [QUO_BITS+1];
   logic [REM_WIDTH-1:0] remx_ff [QUO_BITS+1];
   logic [REM_WIDTH-1:0] remy_ff [QUO_BITS+1];
   quo_type              qx_ff   [QUO_BITS+1];
   quo_type              qy_ff   [QUO_BITS+1];
   num_type              den_ff  [QUO_BITS+1];
   meta_type             meta_ff [QUO_BITS+1];
   logic                 ox_ff   [QUO_BITS+1];
   logic                 oy_ff   [QUO_BITS+1];

   logic [REM_WIDTH-1:0] lim;
   logic                 ox_in, oy_in;

   assign en[QUO_BITS] = !v_ff[QUO_BITS] || out_ready;
   assign in_ready     = en[0];

   assign lim   = REM_WIDTH'(den) << QUO_BITS;
   assign ox_in = REM_WIDTH'(num_x) >= lim;
   assign oy_in = REM_WIDTH'(num_y) >= lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         remx_ff[0] <= REM_WIDTH'(num_x);
         remy_ff[0] <= REM_WIDTH'(num_y);
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         den_ff[0]  <= den;
         meta_ff[0] <= meta_in;
         ox_ff[0]   <= ox_in;
         oy_ff[0]   <= oy_in;
      end
   end

   for (genvar s = 1; s <= QUO_BITS; s++) begin : g_stage
      localparam int K = QUO_BITS - s;

      logic [REM_WIDTH-1:0] sub;
      logic                 gex, gey;
      logic [REM_WIDTH-1:0] remx_in, remy_in;
      quo_type              qx_in, qy_in;

      assign en[s-1] = !v_ff[s-1] || en[s];

      always_comb begin
         sub     = REM_WIDTH'(den_ff[s-1]) << K;
         gex     = remx_ff[s-1] >= sub;
         gey     = remy_ff[s-1] >= sub;
         remx_in = gex ? remx_ff[s-1] - sub : remx_ff[s-1];
         remy_in = gey ? remy_ff[s-1] - sub : remy_ff[s-1];
         qx_in   = qx_ff[s-1];
         qy_in   = qy_ff[s-1];
         qx_in[K] = gex;
         qy_in[K] = gey;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            remx_ff[s] <= remx_in;
            remy_ff[s] <= remy_in;
            qx_ff[s]   <= qx_in;
            qy_ff[s]   <= qy_in;
            den_ff[s]  <= den_ff[s-1];
            meta_ff[s] <= meta_ff[s-1];
            ox_ff[s]   <= ox_ff[s-1];
            oy_ff[s]   <= oy_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[QUO_BITS];
   assign quo_x     = qx_ff[QUO_BITS];
   assign quo_y     = qy_ff[QUO_BITS];
   assign ovf_x     = ox_ff[QUO_BITS];
   assign ovf_y     = oy_ff[QUO_BITS];
   assign meta_out  = meta_ff[QUO_BITS];

endmodule

`default_nettype wire

@@ rtl/core/vertex_world_to_screen_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake               | payload
// request   | in        | req_valid / req_ready   | req_vertex_x, req_vertex_y, req_vertex_z
// response  | out       | rsp_valid / rsp_ready   | rsp_screen_x, rsp_screen_y, rsp_clipped,
//           |           |                         | rsp_on_screen, rsp_zero_w
// csr       | in        | csr_we (no wait)        | csr_index, csr_wdata
//
// One request per cycle unless back pressure stalls it; 3 transform stages, 2 setup
// stages (divisor and size multiply), 18 divider stages (an input register, then one
// quotient bit per stage over 17 bits), one output register. Synchronous reset clears
// all valid bits and loads the identity matrix, zero camera and a 640x480 screen.
// Every stage holds while the next one is full and stalled, so back pressure fills
// bubbles first and drops nothing.

module vertex_world_to_screen_top
   import vwts_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_vertex_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [OUT_WIDTH-1:0]        rsp_screen_x,
   output logic signed [OUT_WIDTH-1:0]        rsp_screen_y,
   output logic                               rsp_clipped,
   output logic                               rsp_on_screen,
   output logic                               rsp_zero_w,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_3 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAMERA_X = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAMERA_Y = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAMERA_Z = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN   = 3'd7;

   localparam logic [COEF_WIDTH-1:0] COEF_ONE = 16'd1024;
   localparam logic [31:0]           SCREEN_RESET = 32'd31457920;

   matrix_type                     matrix_ff;
   logic signed [COORD_WIDTH-1:0]  camx_ff, camy_ff, camz_ff;
   logic [31:0]                    screen_ff;
   logic [SIZE_WIDTH-1:0]          width, height;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            matrix_ff[i] <= CSR_DATA_WIDTH'(COEF_ONE) << (COEF_WIDTH * i);
         end
         camx_ff   <= '0;
         camy_ff   <= '0;
         camz_ff   <= '0;
         screen_ff <= SCREEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index) inside
            CSR_MATRIX_0, CSR_MATRIX_1, CSR_MATRIX_2, CSR_MATRIX_3:
               matrix_ff[csr_index[1:0]] <= csr_wdata;
            CSR_CAMERA_X: camx_ff   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_CAMERA_Y: camy_ff   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_CAMERA_Z: camz_ff   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_SCREEN:   screen_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign width  = screen_ff[SIZE_WIDTH-1:0];
   assign height = screen_ff[2*SIZE_WIDTH-1:SIZE_WIDTH];

   logic         xf_valid, xf_ready;
   clip_type     clip [4];
   logic         pr_valid, pr_ready;
   dividend_type num_x, num_y;
   num_type      den;
   meta_type     pr_meta, dv_meta;
   logic         dv_valid, dv_ready;
   quo_type      quo_x, quo_y;
   logic         ovf_x, ovf_y;

   vwts_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .vertex_x  (req_vertex_x),
      .vertex_y  (req_vertex_y),
      .vertex_z  (req_vertex_z),
      .camera_x  (camx_ff),
      .camera_y  (camy_ff),
      .camera_z  (camz_ff),
      .matrix    (matrix_ff),
      .out_valid (xf_valid),
      .out_ready (xf_ready),
      .clip_out  (clip)
   );

   vwts_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xf_valid),
      .in_ready  (xf_ready),
      .clip_in   (clip),
      .width     (width),
      .height    (height),
      .out_valid (pr_valid),
      .out_ready (pr_ready),
      .num_x     (num_x),
      .num_y     (num_y),
      .den       (den),
      .meta      (pr_meta)
   );

   vwts_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pr_valid),
      .in_ready  (pr_ready),
      .num_x     (num_x),
      .num_y     (num_y),
      .den       (den),
      .meta_in   (pr_meta),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .quo_x     (quo_x),
      .quo_y     (quo_y),
      .ovf_x     (ovf_x),
      .ovf_y     (ovf_y),
      .meta_out  (dv_meta)
   );

   function automatic logic [OUT_WIDTH-1:0] saturate(input quo_type q, input logic ovf,
                                                      input logic neg);
      logic [OUT_WIDTH-1:0] r;
      if (neg) begin
         r = (ovf || (q[QUO_BITS-1] && (q[QUO_BITS-2:0] != '0))) ? OUT_MIN : -q;
      end else begin
         r = (ovf || q[QUO_BITS-1]) ? OUT_MAX : q;
      end
      return r;
   endfunction

   logic                 out_en;
   logic                 valid_ff;
   logic [OUT_WIDTH-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic                 on_in, on_ff, clip_ff, zw_ff;

   assign out_en   = !valid_ff || rsp_ready;
   assign dv_ready = out_en;

   always_comb begin
      logic [OUT_WIDTH-1:0] tx, ty;
      tx = saturate(quo_x, ovf_x, dv_meta.neg_x);
      ty = saturate(quo_y, ovf_y, dv_meta.neg_y);
      if (dv_meta.clipped) begin
         sx_in = OUT_CLIP;
         sy_in = OUT_CLIP;
         on_in = 1'b0;
      end else begin
         sx_in = tx;
         sy_in = ty;
         on_in = !tx[OUT_WIDTH-1] && (tx < OUT_WIDTH'(width))
              && !ty[OUT_WIDTH-1] && (ty < OUT_WIDTH'(height));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_en) begin
         valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         on_ff   <= on_in;
         clip_ff <= dv_meta.clipped;
         zw_ff   <= dv_meta.zero_w;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_screen_x  = $signed(sx_ff);
   assign rsp_screen_y  = $signed(sy_ff);
   assign rsp_clipped   = clip_ff;
   assign rsp_on_screen = on_ff;
   assign rsp_zero_w    = zw_ff;

endmodule

`default_nettype wire
